@@ src/compare_match_timer_assert.svh @@
// assertion macros for the compare match timer
`ifndef COMPARE_MATCH_TIMER_ASSERT_SVH
`define COMPARE_MATCH_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define CMT_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("compare_match_timer: check failed");

// consequent must hold in the same cycle as the antecedent
`define CMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compare_match_timer: check failed");

// consequent must hold in the cycle after the antecedent
`define CMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compare_match_timer: check failed");

`else

`define CMT_ASSERT(label, cond)
`define CMT_ASSERT_IMP(label, ante, cons)
`define CMT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/cmt_pkg.sv @@
// shared constants and types for the compare match timer
`default_nettype none

package cmt_pkg;

    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int NARROW_WIDTH     = 16;
    localparam int DATA_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH   = 2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    typedef enum logic [0:0] {
        CFG_COUNT_MODE     = 1'b0,
        CFG_PRESCALE_SHIFT = 1'b1
    } cfg_index_t;

    localparam logic [2:0] ADDR_CTRL     = 3'd0;
    localparam logic [2:0] ADDR_INTENSET = 3'd1;
    localparam logic [2:0] ADDR_INTENCLR = 3'd2;
    localparam logic [2:0] ADDR_FLAGS    = 3'd3;
    localparam logic [2:0] ADDR_COUNT    = 3'd4;
    localparam logic [2:0] ADDR_COMPARE0 = 3'd5;

    // ctrl register bits
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_SWRST_BIT  = 1;

endpackage

`default_nettype wire

@@ src/compare_match_timer.sv @@
// a transaction's result is presented in the cycle after it is accepted
// throughput: one transaction per cycle when not stalled; the state update is a single pass
// through the counter increment and compare logic feeding the state registers
// a result held by out_stall holds off the input until it is taken
// reset: async active-low, clears counter, prescaler, compares, flags, enables, config
`default_nettype none

`include "compare_match_timer_assert.svh"

module compare_match_timer #(
    parameter int COUNT_WIDTH  = cmt_pkg::COUNT_WIDTH_DEF,
    parameter int NUM_CHANNELS = cmt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write_en,
    input  wire logic                                cfg_index,
    input  wire logic [cmt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [2:0]                          reg_addr,
    input  wire logic [cmt_pkg::DATA_WIDTH-1:0]      write_data,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [cmt_pkg::DATA_WIDTH-1:0]           read_data,
    output logic                                     irq,
    output logic                                     addr_error
);

    localparam logic [COUNT_WIDTH-1:0] NARROW_MASK =
        COUNT_WIDTH'({cmt_pkg::NARROW_WIDTH{1'b1}});
    localparam logic [COUNT_WIDTH-1:0] WIDE_MASK = {COUNT_WIDTH{1'b1}};

    // configuration
    logic                       count_mode_reg;
    logic [1:0]                 prescale_shift_reg;

    // timer state
    logic [COUNT_WIDTH-1:0]     counter_reg, counter_next;
    logic [2:0]                 prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0]     compare_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]     compare_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    flags_reg, flags_next;
    logic [NUM_CHANNELS-1:0]    irq_en_reg, irq_en_next;
    logic                       run_reg, run_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [cmt_pkg::DATA_WIDTH-1:0] read_data_reg, read_data_next;
    logic                       irq_reg, irq_next;
    logic                       addr_error_reg, addr_error_next;

    logic                       accept;
    logic [COUNT_WIDTH-1:0]     wrap_mask;
    logic [COUNT_WIDTH-1:0]     counter_inc;
    logic [3:0]                 prescale_period;
    logic                       addr_known;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign wrap_mask       = count_mode_reg ? WIDE_MASK : NARROW_MASK;
    assign counter_inc     = (counter_reg + COUNT_WIDTH'(1)) & wrap_mask;
    assign prescale_period = 4'd1 << prescale_shift_reg;
    assign addr_known      = {1'b0, reg_addr} <
                             (4'(cmt_pkg::ADDR_COMPARE0) + 4'(NUM_CHANNELS));

    always_comb
    begin
        counter_next        = counter_reg;
        prescale_count_next = prescale_count_reg;
        compare_next        = compare_reg;
        flags_next          = flags_reg;
        irq_en_next         = irq_en_reg;
        run_next            = run_reg;
        read_data_next      = '0;
        addr_error_next     = 1'b0;

        case (req_type)
            cmt_pkg::REQ_TICK:
            begin
                if (run_reg)
                begin
                    if (({1'b0, prescale_count_reg} + 4'd1) < prescale_period)
                    begin
                        prescale_count_next = prescale_count_reg + 3'd1;
                    end
                    else
                    begin
                        prescale_count_next = '0;
                        counter_next        = counter_inc;
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            if ((compare_reg[c] & wrap_mask) == counter_inc)
                            begin
                                flags_next[c] = 1'b1;
                            end
                        end
                    end
                end
            end
            cmt_pkg::REQ_WRITE, cmt_pkg::REQ_READ:
            begin
                if (!addr_known)
                begin
                    addr_error_next = 1'b1;
                end
                else
                begin
                    case (reg_addr)
                        cmt_pkg::ADDR_CTRL:
                        begin
                            if (req_type == cmt_pkg::REQ_WRITE)
                            begin
                                if (write_data[cmt_pkg::CTRL_SWRST_BIT])
                                begin
                                    // software reset wins over enable
                                    counter_next        = '0;
                                    prescale_count_next = '0;
                                    for (int c = 0; c < NUM_CHANNELS; c++)
                                    begin
                                        compare_next[c] = '0;
                                    end
                                    flags_next  = '0;
                                    irq_en_next = '0;
                                    run_next    = 1'b0;
                                end
                                else
                                begin
                                    run_next = write_data[cmt_pkg::CTRL_ENABLE_BIT];
                                end
                            end
                            else
                            begin
                                read_data_next = cmt_pkg::DATA_WIDTH'(run_reg);
                            end
                        end
                        cmt_pkg::ADDR_INTENSET:
                        begin
                            if (req_type == cmt_pkg::REQ_WRITE)
                                irq_en_next = irq_en_reg | write_data[NUM_CHANNELS-1:0];
                            else
                                read_data_next = cmt_pkg::DATA_WIDTH'(irq_en_reg);
                        end
                        cmt_pkg::ADDR_INTENCLR:
                        begin
                            if (req_type == cmt_pkg::REQ_WRITE)
                                irq_en_next = irq_en_reg & ~write_data[NUM_CHANNELS-1:0];
                            else
                                read_data_next = cmt_pkg::DATA_WIDTH'(irq_en_reg);
                        end
                        cmt_pkg::ADDR_FLAGS:
                        begin
                            if (req_type == cmt_pkg::REQ_WRITE)
                                flags_next = flags_reg & ~write_data[NUM_CHANNELS-1:0];
                            else
                                read_data_next = cmt_pkg::DATA_WIDTH'(flags_reg);
                        end
                        cmt_pkg::ADDR_COUNT:
                        begin
                            // a count load never sets a match flag
                            if (req_type == cmt_pkg::REQ_WRITE)
                                counter_next = write_data[COUNT_WIDTH-1:0] & wrap_mask;
                            else
                                read_data_next =
                                    cmt_pkg::DATA_WIDTH'(counter_reg & wrap_mask);
                        end
                        default:
                        begin
                            // compare channels; a channel past the top address has no register
                            for (int c = 0; c < NUM_CHANNELS; c++)
                            begin
                                if ({1'b0, reg_addr} ==
                                    (4'(cmt_pkg::ADDR_COMPARE0) + 4'(c)))
                                begin
                                    if (req_type == cmt_pkg::REQ_WRITE)
                                        compare_next[c] = write_data[COUNT_WIDTH-1:0];
                                    else
                                        read_data_next =
                                            cmt_pkg::DATA_WIDTH'(compare_reg[c]);
                                end
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // unused request code does nothing
            end
        endcase

        irq_next       = |(flags_next & irq_en_next);
        out_valid_next = accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg     <= 1'b0;
            prescale_shift_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                cmt_pkg::CFG_COUNT_MODE:     count_mode_reg     <= cfg_data[0];
                cmt_pkg::CFG_PRESCALE_SHIFT: prescale_shift_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg        <= '0;
            prescale_count_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                compare_reg[c] <= '0;
            end
            flags_reg          <= '0;
            irq_en_reg         <= '0;
            run_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                counter_reg        <= counter_next;
                prescale_count_reg <= prescale_count_next;
                compare_reg        <= compare_next;
                flags_reg          <= flags_next;
                irq_en_reg         <= irq_en_next;
                run_reg            <= run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg  <= read_data_next;
            irq_reg        <= irq_next;
            addr_error_reg <= addr_error_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign irq        = irq_reg;
    assign addr_error = addr_error_reg;

    // an address error never carries read data
    `CMT_ASSERT_IMP(a_err_no_data, out_valid_reg && addr_error_reg, read_data_reg == '0)

    // irq result reflects the state left behind by the transaction
    `CMT_ASSERT_NEXT(a_irq_matches_state, accept, irq_reg == |(flags_reg & irq_en_reg))

    // software reset clears the timer
    `CMT_ASSERT_NEXT(a_swrst_clears,
        accept && req_type == cmt_pkg::REQ_WRITE && reg_addr == cmt_pkg::ADDR_CTRL
            && write_data[cmt_pkg::CTRL_SWRST_BIT],
        counter_reg == '0 && flags_reg == '0 && irq_en_reg == '0 && !run_reg)

    // ticks while stopped leave the counter and prescaler alone
    `CMT_ASSERT_NEXT(a_stopped_holds, accept && req_type == cmt_pkg::REQ_TICK && !run_reg,
        $stable(counter_reg) && $stable(prescale_count_reg))

endmodule

`default_nettype wire
